### hw/rtl/qdec_pkg.sv
// Shared types and constants for the two-channel quadrature decoder.
// No dependencies; used by the interfaces and all decoder modules.
`default_nettype none

package qdec_pkg;

   // Fixed field widths
   localparam int TICK_WIDTH      = 7;
   localparam int GAIN_WIDTH      = 4;
   localparam int STEP_WIDTH      = 2;
   localparam int DELTA_WIDTH     = 10;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 7;

   // Default accumulator width
   localparam int ACCUM_WIDTH_DEF = 8;

   // Register reset values
   localparam logic [TICK_WIDTH-1:0] THRESHOLD_RESET = 7'd20;
   localparam logic [TICK_WIDTH-1:0] WRAP_RESET      = 7'd100;
   localparam logic [GAIN_WIDTH-1:0] GAIN_RESET      = 4'd10;
   localparam logic [STEP_WIDTH-1:0] STEP_RESET      = 2'd3;

   // Operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FAST_LIMIT      = 2'd0,
      CSR_TICK_WRAP_LIMIT = 2'd1,
      CSR_ACCEL_GAIN      = 2'd2
   } csr_index_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [TICK_WIDTH-1:0] fast_limit;
      logic [TICK_WIDTH-1:0] tick_wrap_limit;
      logic [GAIN_WIDTH-1:0] accel_gain;
   } cfg_type;

   // Per-channel command from the input stage
   typedef struct packed {
      logic tick;
      logic read;
      logic pin_a;
      logic pin_b;
   } chan_cmd_type;

endpackage

`default_nettype wire

### hw/rtl/qdec_if.sv
// Valid/ready channel interfaces: request, response and register write.
// Depends on qdec_pkg for field widths.
`default_nettype none

interface qdec_req_if;
   logic valid;
   logic ready;
   logic op;
   logic ch1_a;
   logic ch1_b;
   logic ch2_a;
   logic ch2_b;
   logic read_channel;

   modport source (output valid, op, ch1_a, ch1_b, ch2_a, ch2_b, read_channel,
                   input ready);
   modport sink   (input valid, op, ch1_a, ch1_b, ch2_a, ch2_b, read_channel,
                   output ready);
endinterface

interface qdec_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [qdec_pkg::DELTA_WIDTH-1:0]  delta;

   modport source (output valid, delta, input ready);
   modport sink   (input valid, delta, output ready);
endinterface

interface qdec_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [qdec_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [qdec_pkg::CSR_DATA_WIDTH-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/qdec_chan.sv
// One encoder channel: tick counter, acceleration flag, last step, accumulator.
// Depends on qdec_pkg.
`default_nettype none

module qdec_chan
   import qdec_pkg::*;
#(
   parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire chan_cmd_type                  cmd,
   input  wire cfg_type                       cfg,
   output logic                               accel,
   output logic signed [ACCUM_WIDTH-3:0]      read_val
);

   logic [TICK_WIDTH-1:0]  tick_count_ff, tick_count_in;
   logic                   accel_ff, accel_in;
   logic [STEP_WIDTH-1:0]  last_step_ff, last_step_in;
   logic [ACCUM_WIDTH-1:0] accum_ff, accum_in;

   logic [TICK_WIDTH-1:0]  tick_inc;
   logic [TICK_WIDTH-1:0]  tick_adv;
   logic [STEP_WIDTH-1:0]  step;
   logic [STEP_WIDTH-1:0]  diff;

   // Advance the tick counter, wrapping past the limit
   assign tick_inc = tick_count_ff + TICK_WIDTH'(1);
   assign tick_adv = (tick_inc > cfg.tick_wrap_limit) ? '0 : tick_inc;

   // Pin levels to step code: A gives 3, B flips bit 0
   assign step = {cmd.pin_a, cmd.pin_a ^ cmd.pin_b};
   assign diff = last_step_ff - step;

   // Arithmetic shift right by 2 is just the upper bits
   assign read_val = $signed(accum_ff[ACCUM_WIDTH-1:2]);
   assign accel    = accel_ff;

   // Next-state logic
   always_comb begin
      tick_count_in = tick_count_ff;
      accel_in      = accel_ff;
      last_step_in  = last_step_ff;
      accum_in      = accum_ff;
      if (cmd.tick) begin
         tick_count_in = tick_adv;
         // odd difference is a real transition
         if (diff[0]) begin
            accel_in      = (tick_adv < cfg.fast_limit);
            tick_count_in = '0;
            last_step_in  = step;
            if (diff[1]) begin
               accum_in = accum_ff - ACCUM_WIDTH'(1);
            end else begin
               accum_in = accum_ff + ACCUM_WIDTH'(1);
            end
         end
      end else if (cmd.read) begin
         // keep the sub-detent remainder
         accum_in = {{(ACCUM_WIDTH-2){1'b0}}, accum_ff[1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         accel_ff      <= 1'b0;
         last_step_ff  <= STEP_RESET;
         accum_ff      <= '0;
      end else begin
         tick_count_ff <= tick_count_in;
         accel_ff      <= accel_in;
         last_step_ff  <= last_step_in;
         accum_ff      <= accum_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/qdec_scale.sv
// Read scaling: optional gain multiply and saturation to the delta range.
// Depends on qdec_pkg.
`default_nettype none

module qdec_scale
   import qdec_pkg::*;
#(
   parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
   input  wire logic signed [ACCUM_WIDTH-3:0]  value,
   input  wire logic                           accel,
   input  wire logic [GAIN_WIDTH-1:0]          gain,
   output logic signed [DELTA_WIDTH-1:0]       delta
);

   localparam int PROD_WIDTH = ACCUM_WIDTH - 2 + GAIN_WIDTH + 1;
   localparam int SAT_WIDTH  = (PROD_WIDTH > DELTA_WIDTH) ? PROD_WIDTH : DELTA_WIDTH;
   localparam logic signed [SAT_WIDTH-1:0] DELTA_MAX = SAT_WIDTH'(2**(DELTA_WIDTH-1) - 1);
   localparam logic signed [SAT_WIDTH-1:0] DELTA_MIN = -DELTA_MAX - SAT_WIDTH'(1);

   logic signed [PROD_WIDTH-1:0] prod;
   logic signed [SAT_WIDTH-1:0]  scaled;

   // Gain is unsigned; zero-extend it before the signed multiply
   assign prod   = value * $signed({1'b0, gain});
   assign scaled = accel ? SAT_WIDTH'(prod) : SAT_WIDTH'(value);

   // Clamp to the delta range
   always_comb begin
      if (scaled > DELTA_MAX) begin
         delta = DELTA_MAX[DELTA_WIDTH-1:0];
      end else if (scaled < DELTA_MIN) begin
         delta = DELTA_MIN[DELTA_WIDTH-1:0];
      end else begin
         delta = scaled[DELTA_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/quadrature_decoder_accel_core.sv
// Two-channel quadrature decoder with acceleration, top level.
// A read request is held in the input register, then its delta in the response register.
// Throughput: one item per cycle; the input register moves on as long as the
// response register is free or being drained, and ticks never wait on it.
// Reset: synchronous, restores registers to defaults and clears channel state.
// Depends on qdec_pkg, qdec_if, qdec_chan and qdec_scale.
`default_nettype none

module quadrature_decoder_accel_core
   import qdec_pkg::*;
#(
   parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   qdec_req_if.sink   req_ch,
   qdec_rsp_if.source rsp_ch,
   qdec_csr_if.sink   csr_ch
);

   // Configuration registers
   cfg_type cfg_ff, cfg_in;

   // Input stage
   logic s1_valid_ff, s1_valid_in;
   logic s1_op_ff, s1_ch1_a_ff, s1_ch1_b_ff, s1_ch2_a_ff, s1_ch2_b_ff, s1_rd_ch_ff;
   logic s1_go;
   logic req_xfer;

   // Output stage
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [DELTA_WIDTH-1:0] rsp_delta_ff;
   logic                          rsp_load;

   // Channel datapath
   chan_cmd_type                   cmd1, cmd2;
   logic                           accel1, accel2, accel_sel;
   logic signed [ACCUM_WIDTH-3:0]  val1, val2, val_sel;
   logic signed [DELTA_WIDTH-1:0]  delta_next;

   // Register writes; always ready
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_FAST_LIMIT:      cfg_in.fast_limit      = csr_ch.data[TICK_WIDTH-1:0];
            CSR_TICK_WRAP_LIMIT: cfg_in.tick_wrap_limit = csr_ch.data[TICK_WIDTH-1:0];
            CSR_ACCEL_GAIN:      cfg_in.accel_gain      = csr_ch.data[GAIN_WIDTH-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_limit      <= THRESHOLD_RESET;
         cfg_ff.tick_wrap_limit <= WRAP_RESET;
         cfg_ff.accel_gain      <= GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input stage handshake: ticks always proceed, reads need a free output slot
   assign s1_go        = s1_valid_ff && ((s1_op_ff == OP_TICK) || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_op_ff    <= req_ch.op;
         s1_ch1_a_ff <= req_ch.ch1_a;
         s1_ch1_b_ff <= req_ch.ch1_b;
         s1_ch2_a_ff <= req_ch.ch2_a;
         s1_ch2_b_ff <= req_ch.ch2_b;
         s1_rd_ch_ff <= req_ch.read_channel;
      end
   end

   // Per-channel commands
   always_comb begin
      cmd1.tick  = s1_go && (s1_op_ff == OP_TICK);
      cmd1.read  = s1_go && (s1_op_ff == OP_READ) && !s1_rd_ch_ff;
      cmd1.pin_a = s1_ch1_a_ff;
      cmd1.pin_b = s1_ch1_b_ff;
      cmd2.tick  = s1_go && (s1_op_ff == OP_TICK);
      cmd2.read  = s1_go && (s1_op_ff == OP_READ) && s1_rd_ch_ff;
      cmd2.pin_a = s1_ch2_a_ff;
      cmd2.pin_b = s1_ch2_b_ff;
   end

   qdec_chan #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_chan1 (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd1),
      .cfg      (cfg_ff),
      .accel    (accel1),
      .read_val (val1)
   );

   qdec_chan #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_chan2 (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd2),
      .cfg      (cfg_ff),
      .accel    (accel2),
      .read_val (val2)
   );

   // Select the channel being read
   assign val_sel   = s1_rd_ch_ff ? val2 : val1;
   assign accel_sel = s1_rd_ch_ff ? accel2 : accel1;

   qdec_scale #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_scale (
      .value (val_sel),
      .accel (accel_sel),
      .gain  (cfg_ff.accel_gain),
      .delta (delta_next)
   );

   // Response register
   assign rsp_load     = s1_go && (s1_op_ff == OP_READ);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_delta_ff <= delta_next;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.delta = rsp_delta_ff;

endmodule

`default_nettype wire

### tb/sv/qdec_delta_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the two-channel quadrature decoder: watches the request,
// response and register-write channels, predicts every read's delta and
// compares results in order. Depends on qdec_pkg and the qdec_if interfaces.

module qdec_delta_checker
   import qdec_pkg::*;
#(
   parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   qdec_req_if  req_ch,
   qdec_rsp_if  rsp_ch,
   qdec_csr_if  csr_ch,
   output int   fail_count,
   output int   pending_count,
   output int   checked_count,
   output int   scaled_count
);

   localparam int DELTA_HI = 2 ** (DELTA_WIDTH - 1) - 1;
   localparam int DELTA_LO = -(2 ** (DELTA_WIDTH - 1));

   // Shadow registers and per-channel decoder state
   cfg_type                cfg;
   logic [TICK_WIDTH-1:0]  tick_age   [2];
   logic                   fast_flag  [2];
   logic [STEP_WIDTH-1:0]  prev_code  [2];
   logic [ACCUM_WIDTH-1:0] detent_acc [2];

   // Deltas still owed by the block, oldest first
   logic [DELTA_WIDTH-1:0] delta_expect_q [$];
   logic [DELTA_WIDTH-1:0] delta_want;

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("[%0t] %s", $time, what);
   endtask

   // Tick: age both counters first, then look at the new pin levels
   task automatic sample_pins(input logic [1:0] pin_a, input logic [1:0] pin_b);
      logic [TICK_WIDTH-1:0] age;
      logic [STEP_WIDTH-1:0] code;
      logic [STEP_WIDTH-1:0] diff;
      for (int c = 0; c < 2; c++) begin
         age = tick_age[c] + 1'b1;
         if (age > cfg.tick_wrap_limit)
            age = '0;
         tick_age[c] = age;
      end
      for (int c = 0; c < 2; c++) begin
         // A high gives code 3, B flips bit 0
         code = {pin_a[c], pin_a[c] ^ pin_b[c]};
         diff = prev_code[c] - code;
         // odd difference is one quadrature step; even means idle or skipped
         if (diff[0]) begin
            fast_flag[c]  = tick_age[c] < cfg.fast_limit;
            tick_age[c]   = '0;
            prev_code[c]  = code;
            detent_acc[c] = diff[1] ? detent_acc[c] - 1'b1 : detent_acc[c] + 1'b1;
         end
      end
   endtask

   // Read: whole detents since last read, remainder kept, gain when fast
   task automatic predict_read(input int c);
      logic signed [ACCUM_WIDTH-1:0] raw;
      int                            value;
      raw   = detent_acc[c];
      value = int'(raw) >>> 2;
      detent_acc[c]      = '0;
      detent_acc[c][1:0] = raw[1:0];
      if (fast_flag[c]) begin
         value = value * int'(cfg.accel_gain);
         scaled_count++;
      end
      if (value > DELTA_HI)
         value = DELTA_HI;
      else if (value < DELTA_LO)
         value = DELTA_LO;
      delta_expect_q.push_back(value[DELTA_WIDTH-1:0]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg = '{fast_limit:      THRESHOLD_RESET,
                 tick_wrap_limit: WRAP_RESET,
                 accel_gain:      GAIN_RESET};
         for (int c = 0; c < 2; c++) begin
            tick_age[c]   = '0;
            fast_flag[c]  = 1'b0;
            prev_code[c]  = STEP_RESET;
            detent_acc[c] = '0;
         end
         delta_expect_q.delete();
      end else begin
         // result transfer against the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (delta_expect_q.size() == 0) begin
               report_mismatch($sformatf("delta %0d with no read outstanding",
                                         $signed(rsp_ch.delta)));
            end else begin
               delta_want = delta_expect_q.pop_front();
               checked_count++;
               if (rsp_ch.delta !== delta_want)
                  report_mismatch($sformatf("delta got %0d, want %0d",
                                            $signed(rsp_ch.delta), $signed(delta_want)));
            end
         end
         // register write
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_FAST_LIMIT:      cfg.fast_limit      = csr_ch.data[TICK_WIDTH-1:0];
               CSR_TICK_WRAP_LIMIT: cfg.tick_wrap_limit = csr_ch.data[TICK_WIDTH-1:0];
               CSR_ACCEL_GAIN:      cfg.accel_gain      = csr_ch.data[GAIN_WIDTH-1:0];
               default: ;
            endcase
         end
         // request transfer
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.op == OP_READ)
               predict_read(int'(req_ch.read_channel));
            else
               sample_pins({req_ch.ch2_a, req_ch.ch1_a}, {req_ch.ch2_b, req_ch.ch1_b});
         end
      end
      pending_count = delta_expect_q.size();
   end

endmodule

### tb/sv/tb_quadrature_decoder_accel_core.sv
`timescale 1ns / 100ps
// Testbench top for the quadrature decoder: clock, reset, encoder stimulus,
// response pacing, watchdog and verdict. Depends on qdec_pkg, qdec_if,
// quadrature_decoder_accel_core and qdec_delta_checker.

module tb_quadrature_decoder_accel_core
   import qdec_pkg::*;
();

   localparam int PHASE_ITEMS   = 320;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 8;

   typedef enum int {PACE_FAST, PACE_SLOW, PACE_PARKED} pace_type;

   logic clock = 1'b0;
   logic reset;

   qdec_req_if req_ch();
   qdec_rsp_if rsp_ch();
   qdec_csr_if csr_ch();

   int fail_count;
   int pending_count;
   int checked_count;
   int scaled_count;
   int items_sent;
   int reads_sent;
   int settings_used;
   int stall_cycles;

   bit sender_idles;   // sender may insert gaps
   bit quiet_tail;     // no idling on either side
   bit hold_request;   // ask the receiver for one long hold-off

   // Simulated encoder shafts
   logic [1:0] enc_pos   [2];
   int         enc_dir   [2];
   int         enc_dwell [2];
   pace_type   enc_pace  [2];

   always #2 clock = ~clock;

   quadrature_decoder_accel_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   qdec_delta_checker #(
      .ACCUM_WIDTH (ACCUM_WIDTH_DEF)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .scaled_count  (scaled_count)
   );

   // Watchdog: any transfer restarts the count
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Response side: ready bursts, random stalls, one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b1;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (quiet_tail || $urandom_range(0, 3) != 0) begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   // One request transfer, with an optional gap ahead of it
   task automatic send_item(input logic op, input logic [1:0] pin_a,
                            input logic [1:0] pin_b, input logic rch);
      if (sender_idles && !quiet_tail && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.op           <= op;
      req_ch.ch1_a        <= pin_a[0];
      req_ch.ch1_b        <= pin_b[0];
      req_ch.ch2_a        <= pin_a[1];
      req_ch.ch2_b        <= pin_b[1];
      req_ch.read_channel <= rch;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      if (op == OP_READ)
         reads_sent++;
   endtask

   // Tick with the pins that give step codes code0 / code1
   task automatic send_codes(input logic [1:0] code0, input logic [1:0] code1);
      logic [1:0] pin_a;
      logic [1:0] pin_b;
      pin_a = {code1[1], code0[1]};
      pin_b = {code1[1] ^ code1[0], code0[1] ^ code0[0]};
      send_item(OP_TICK, pin_a, pin_b, 1'($urandom));
   endtask

   task automatic send_read(input logic rch);
      send_item(OP_READ, 2'($urandom), 2'($urandom), rch);
   endtask

   // Drop valid and wait until every owed delta has come back
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic set_registers(input logic [TICK_WIDTH-1:0] thr,
                                input logic [TICK_WIDTH-1:0] wrap,
                                input logic [GAIN_WIDTH-1:0] gain);
      settle();
      write_reg(CSR_FAST_LIMIT, thr);
      write_reg(CSR_TICK_WRAP_LIMIT, wrap);
      write_reg(CSR_ACCEL_GAIN, CSR_DATA_WIDTH'(gain));
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   // Mostly clean rotation at varying speed, some skips, noise and reads
   task automatic random_item(input int read_pct);
      int roll;
      if ($urandom_range(0, 99) < read_pct) begin
         send_read(1'($urandom));
      end else if ($urandom_range(0, 99) < 8) begin
         send_item(OP_TICK, 2'($urandom), 2'($urandom), 1'($urandom));
      end else begin
         for (int c = 0; c < 2; c++) begin
            if ($urandom_range(0, 99) < 3) begin
               roll = $urandom_range(0, 9);
               enc_pace[c] = (roll < 5) ? PACE_FAST : (roll < 9) ? PACE_SLOW : PACE_PARKED;
            end
            if (enc_dwell[c] > 0) begin
               enc_dwell[c]--;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 5) begin
                  enc_pos[c] = enc_pos[c] + 2'd2;   // skipped step
               end else begin
                  if (roll < 12)
                     enc_dir[c] = -enc_dir[c];
                  enc_pos[c] = (enc_dir[c] > 0) ? enc_pos[c] + 1'b1 : enc_pos[c] - 1'b1;
               end
               case (enc_pace[c])
                  PACE_FAST: enc_dwell[c] = $urandom_range(0, 2);
                  PACE_SLOW: enc_dwell[c] = $urandom_range(15, 40);
                  default:   enc_dwell[c] = $urandom_range(100, 160);
               endcase
            end
         end
         send_codes(enc_pos[0], enc_pos[1]);
      end
   endtask

   task automatic run_phase(input int read_pct);
      repeat (PHASE_ITEMS) random_item(read_pct);
   endtask

   // Main sequence
   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.op           <= OP_TICK;
      req_ch.ch1_a        <= 1'b0;
      req_ch.ch1_b        <= 1'b0;
      req_ch.ch2_a        <= 1'b0;
      req_ch.ch2_b        <= 1'b0;
      req_ch.read_channel <= 1'b0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= CSR_FAST_LIMIT;
      csr_ch.data         <= '0;
      sender_idles = 1'b1;
      quiet_tail   = 1'b0;
      hold_request = 1'b0;
      for (int c = 0; c < 2; c++) begin
         enc_pos[c]   = 2'd2;
         enc_dir[c]   = 1;
         enc_dwell[c] = 0;
         enc_pace[c]  = PACE_FAST;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      settings_used = 1;

      // Directed part under reset-default registers
      send_read(1'b0);                            // empty accumulator
      send_item(OP_READ, 2'b11, 2'b11, 1'b1);     // pin levels ignored on a read
      send_item(OP_TICK, 2'b11, 2'b00, 1'b1);     // same code as reset: no motion
      send_codes(2'd0, 2'd2);                     // fast detent, opposite directions
      send_codes(2'd1, 2'd1);
      send_codes(2'd2, 2'd0);
      send_codes(2'd3, 2'd3);
      send_read(1'b0);
      send_read(1'b1);
      send_codes(2'd1, 2'd3);                     // skipped step on channel one
      send_codes(2'd2, 2'd2);
      send_codes(2'd1, 2'd1);
      send_codes(2'd0, 2'd0);
      send_codes(2'd3, 2'd3);
      send_item(OP_TICK, 2'b11, 2'b11, 1'b0);     // all pins high
      send_item(OP_TICK, 2'b00, 2'b00, 1'b0);     // all pins low, skip on both
      send_read(1'b0);
      send_read(1'b1);
      send_read(1'b1);                            // read right after a read

      // Random phases across register settings
      run_phase(15);

      set_registers(7'd127, 7'd126, 4'd15);      // always fast, top gain
      hold_request = 1'b1;
      run_phase(40);

      sender_idles = 1'b0;
      set_registers(7'd0, 7'd1, 4'd1);           // never fast, tiny wrap
      run_phase(8);

      sender_idles = 1'b1;
      set_registers(7'd5, 7'd127, 4'd7);         // counter wraps through 127
      run_phase(15);

      set_registers(7'($urandom_range(0, 127)), 7'($urandom_range(1, 127)),
                    4'($urandom_range(1, 15)));
      run_phase(20);

      quiet_tail = 1'b1;
      set_registers(THRESHOLD_RESET, WRAP_RESET, GAIN_RESET);
      run_phase(15);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d reads) under %0d register settings, with a %0d-cycle",
               items_sent, reads_sent, settings_used, HOLD_CYCLES);
      $display("response hold-off; %0d deltas compared, %0d of them gain-scaled.",
               checked_count, scaled_count);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
